>>> hw/rtl/htbd_pkg.sv
// Shared command codes, status codes and controller/datapath link types.
`default_nettype none
package htbd_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_BUILD  = 2'd1;
    localparam logic [1:0] CMD_DECODE = 2'd2;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_HEAP_FULL   = 2'd1;
    localparam logic [1:0] ST_NO_TREE     = 2'd2;
    localparam logic [1:0] ST_AFTER_BUILD = 2'd3;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_RESULT,
        OP_INS_START,
        OP_UP_READ,
        OP_UP_STEP,
        OP_PLACE,
        OP_POP_READ,
        OP_POP_TAKE,
        OP_POP_LAST,
        OP_DN_READL,
        OP_DN_READR,
        OP_DN_MOVE,
        OP_MERGE,
        OP_ROOT_READ,
        OP_ROOT_SET,
        OP_DEC_READ,
        OP_DEC_CHILD,
        OP_DEC_FIN
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       phase_b;
        logic [1:0] stat;
    } t_ctl;

    typedef struct packed {
        logic [1:0] cmd;
        logic       tree_ready;
        logic       root_leaf;
        logic       heap_full;
        logic       count_zero;
        logic       count_gt1;
        logic       pos_zero;
        logic       up_less;
        logic       l_in;
        logic       dn_stay;
    } t_sts;

endpackage
`default_nettype wire

>>> hw/rtl/htbd_ifs.sv
// Valid/ready channel interfaces for command items and result items.
`default_nettype none
interface htbd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [7:0]  symbol;
    logic [15:0] weight;
    logic        code_bit;
    logic        last_bit;

    modport source (output valid, cmd, symbol, weight, code_bit, last_bit, input ready);
    modport sink   (input valid, cmd, symbol, weight, code_bit, last_bit, output ready);
endinterface

interface htbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] decoded_symbol;
    logic       emitted;
    logic [1:0] status;

    modport source (output valid, decoded_symbol, emitted, status, input ready);
    modport sink   (input valid, decoded_symbol, emitted, status, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/htbd_ctrl.sv
// Insert, build and decode sequencer: at most one datapath operation per cycle.
`default_nettype none
module htbd_ctrl
    import htbd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_ctl o_ctl
);

    typedef enum logic [15:0] {
        S_IDLE     = 16'b0000_0000_0000_0001,
        S_DISP     = 16'b0000_0000_0000_0010,
        S_UP_RD    = 16'b0000_0000_0000_0100,
        S_UP_CMP   = 16'b0000_0000_0000_1000,
        S_POP_RD   = 16'b0000_0000_0001_0000,
        S_POP_TAKE = 16'b0000_0000_0010_0000,
        S_POP_LAST = 16'b0000_0000_0100_0000,
        S_DN_RDL   = 16'b0000_0000_1000_0000,
        S_DN_RDR   = 16'b0000_0001_0000_0000,
        S_DN_CMP   = 16'b0000_0010_0000_0000,
        S_MERGE    = 16'b0000_0100_0000_0000,
        S_ROOT_RD  = 16'b0000_1000_0000_0000,
        S_ROOT_SET = 16'b0001_0000_0000_0000,
        S_DEC_CH   = 16'b0010_0000_0000_0000,
        S_DEC_FIN  = 16'b0100_0000_0000_0000,
        S_OUT      = 16'b1000_0000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_phase_b, n_phase_b;
    logic   r_in_build, n_in_build;
    logic   up_done;
    logic   pop_done;

    always_comb begin
        n_state       = r_state;
        n_phase_b     = r_phase_b;
        n_in_build    = r_in_build;
        o_ctl.op      = OP_NONE;
        o_ctl.phase_b = r_phase_b;
        o_ctl.stat    = ST_OK;
        up_done       = 1'b0;
        pop_done      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.op = OP_CAPTURE;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_OUT;
                case (i_sts.cmd)
                    CMD_INSERT: begin
                        if (i_sts.tree_ready) begin
                            o_ctl.op   = OP_RESULT;
                            o_ctl.stat = ST_AFTER_BUILD;
                        end else if (i_sts.heap_full) begin
                            o_ctl.op   = OP_RESULT;
                            o_ctl.stat = ST_HEAP_FULL;
                        end else begin
                            o_ctl.op   = OP_INS_START;
                            n_in_build = 1'b0;
                            n_state    = S_UP_RD;
                        end
                    end
                    CMD_BUILD: begin
                        if (i_sts.count_zero) begin
                            o_ctl.op   = OP_RESULT;
                            o_ctl.stat = ST_NO_TREE;
                        end else if (i_sts.count_gt1) begin
                            n_in_build = 1'b1;
                            n_phase_b  = 1'b0;
                            n_state    = S_POP_RD;
                        end else begin
                            n_state = S_ROOT_RD;
                        end
                    end
                    CMD_DECODE: begin
                        if (!i_sts.tree_ready || i_sts.root_leaf) begin
                            o_ctl.op   = OP_RESULT;
                            o_ctl.stat = ST_NO_TREE;
                        end else begin
                            o_ctl.op = OP_DEC_READ;
                            n_state  = S_DEC_CH;
                        end
                    end
                    default: begin
                        o_ctl.op   = OP_RESULT;
                        o_ctl.stat = ST_OK;
                    end
                endcase
            end
            S_UP_RD: begin
                if (i_sts.pos_zero) begin
                    o_ctl.op = OP_PLACE;
                    up_done  = 1'b1;
                end else begin
                    o_ctl.op = OP_UP_READ;
                    n_state  = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_sts.up_less) begin
                    o_ctl.op = OP_UP_STEP;
                    n_state  = S_UP_RD;
                end else begin
                    o_ctl.op = OP_PLACE;
                    up_done  = 1'b1;
                end
            end
            S_POP_RD: begin
                o_ctl.op = OP_POP_READ;
                n_state  = S_POP_TAKE;
            end
            S_POP_TAKE: begin
                o_ctl.op = OP_POP_TAKE;
                n_state  = S_POP_LAST;
            end
            S_POP_LAST: begin
                if (i_sts.count_zero) begin
                    pop_done = 1'b1;
                end else begin
                    o_ctl.op = OP_POP_LAST;
                    n_state  = S_DN_RDL;
                end
            end
            S_DN_RDL: begin
                if (i_sts.l_in) begin
                    o_ctl.op = OP_DN_READL;
                    n_state  = S_DN_RDR;
                end else begin
                    o_ctl.op = OP_PLACE;
                    pop_done = 1'b1;
                end
            end
            S_DN_RDR: begin
                o_ctl.op = OP_DN_READR;
                n_state  = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (i_sts.dn_stay) begin
                    o_ctl.op = OP_PLACE;
                    pop_done = 1'b1;
                end else begin
                    o_ctl.op = OP_DN_MOVE;
                    n_state  = S_DN_RDL;
                end
            end
            S_MERGE: begin
                o_ctl.op  = OP_MERGE;
                n_phase_b = 1'b0;
                n_state   = S_UP_RD;
            end
            S_ROOT_RD: begin
                o_ctl.op = OP_ROOT_READ;
                n_state  = S_ROOT_SET;
            end
            S_ROOT_SET: begin
                o_ctl.op = OP_ROOT_SET;
                n_state  = S_OUT;
            end
            S_DEC_CH: begin
                o_ctl.op = OP_DEC_CHILD;
                n_state  = S_DEC_FIN;
            end
            S_DEC_FIN: begin
                o_ctl.op = OP_DEC_FIN;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // an insert ends after its sift-up; a build merges until one entry remains
        if (up_done) begin
            if (!r_in_build) begin
                n_state = S_OUT;
            end else if (i_sts.count_gt1) begin
                n_phase_b = 1'b0;
                n_state   = S_POP_RD;
            end else begin
                n_state = S_ROOT_RD;
            end
        end
        if (pop_done) begin
            if (r_phase_b) begin
                n_state = S_MERGE;
            end else begin
                n_phase_b = 1'b1;
                n_state   = S_POP_RD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase_b  <= 1'b0;
            r_in_build <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase_b  <= n_phase_b;
            r_in_build <= n_in_build;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    a_merge_after_second_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE) |-> (r_phase_b && r_in_build))
        else $error("merge entered without two popped entries");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !i_out_ready) |=> (r_state == S_OUT))
        else $error("result dropped before transaction");

    a_capture_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.op == OP_CAPTURE) |-> (r_state == S_IDLE && i_in_valid))
        else $error("capture outside an accepted transaction");

endmodule
`default_nettype wire

>>> hw/rtl/htbd_dpath.sv
// Heap memory, node memory, counters and decode cursor driven by controller operations.
`default_nettype none
module htbd_dpath
    import htbd_pkg::*;
#(
    parameter int MAX_SYMBOLS = 256,
    parameter int WEIGHT_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctl        i_ctl,
    output t_sts        o_sts,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_symbol,
    input  logic [15:0] i_weight,
    input  logic        i_code_bit,
    input  logic        i_last_bit,
    output logic [7:0]  o_decoded_symbol,
    output logic        o_emitted,
    output logic [1:0]  o_status
);

    localparam int NDEPTH = 2 * MAX_SYMBOLS - 1;
    localparam int NAW    = $clog2(NDEPTH);
    localparam int NUW    = $clog2(NDEPTH + 1);
    localparam int HAW    = $clog2(MAX_SYMBOLS);
    localparam int CW     = $clog2(MAX_SYMBOLS + 1);
    localparam int IW     = CW + 1;
    localparam logic [WEIGHT_BITS-1:0] WMAX = '1;

    typedef struct packed {
        logic [WEIGHT_BITS-1:0] w;
        logic [NAW-1:0]         idx;
    } t_entry;

    typedef struct packed {
        logic [7:0]     sym;
        logic           leaf;
        logic [NAW-1:0] left;
        logic [NAW-1:0] right;
    } t_node;

    t_entry r_heap_mem [MAX_SYMBOLS];
    t_node  r_node_mem [NDEPTH];

    // control state
    logic [CW-1:0]  r_count;
    logic [NUW-1:0] r_nodes;
    logic [NAW-1:0] r_root;
    logic [NAW-1:0] r_cursor;
    logic           r_tree;
    logic           r_root_leaf;

    // item and working registers
    logic [1:0]     r_cmd;
    logic [7:0]     r_sym;
    logic [15:0]    r_wt;
    logic           r_bit;
    logic           r_last;
    logic [HAW-1:0] r_pos;
    t_entry         r_x;
    t_entry         r_a;
    t_entry         r_b;
    t_entry         r_lent;
    logic           r_rin;
    logic [NAW-1:0] r_child;
    t_entry         r_heap_rd;
    t_node          r_node_rd;
    logic [7:0]     r_osym;
    logic           r_oemit;
    logic [1:0]     r_ostat;

    logic [IW-1:0]          l_ix;
    logic [IW-1:0]          r_ix;
    logic [IW-1:0]          count_ext;
    logic [HAW-1:0]         up_ix;
    logic [CW-1:0]          cnt_m1;
    logic [WEIGHT_BITS-1:0] w_sat;
    logic [WEIGHT_BITS:0]   sum_full;
    logic [WEIGHT_BITS-1:0] sum_sat;
    t_entry                 dn_best;
    logic [HAW-1:0]         dn_bi;
    logic                   dn_moved;
    logic [NAW-1:0]         child_c;
    logic [NAW-1:0]         c_fin;

    logic           hp_we, hp_re;
    logic [HAW-1:0] hp_wa, hp_ra;
    t_entry         hp_wd;
    logic           nd_we, nd_re;
    logic [NAW-1:0] nd_wa, nd_ra;
    t_node          nd_wd;

    assign l_ix      = (IW'(r_pos) << 1) + IW'(1);
    assign r_ix      = l_ix + IW'(1);
    assign count_ext = IW'(r_count);
    assign up_ix     = (r_pos - HAW'(1)) >> 1;
    assign cnt_m1    = r_count - CW'(1);
    assign w_sat     = (32'(r_wt) > 32'(WMAX)) ? WMAX : WEIGHT_BITS'(r_wt);
    assign sum_full  = {1'b0, r_a.w} + {1'b0, r_b.w};
    assign sum_sat   = sum_full[WEIGHT_BITS] ? WMAX : sum_full[WEIGHT_BITS-1:0];
    assign child_c   = r_bit ? r_node_rd.right : r_node_rd.left;
    assign c_fin     = (r_node_rd.leaf || r_last) ? r_root : r_child;

    // smallest of hole item, left child and right child; strict less keeps ties in place
    always_comb begin
        dn_best  = r_x;
        dn_bi    = r_pos;
        dn_moved = 1'b0;
        if (r_lent.w < dn_best.w) begin
            dn_best  = r_lent;
            dn_bi    = l_ix[HAW-1:0];
            dn_moved = 1'b1;
        end
        if (r_rin && (r_heap_rd.w < dn_best.w)) begin
            dn_best  = r_heap_rd;
            dn_bi    = r_ix[HAW-1:0];
            dn_moved = 1'b1;
        end
    end

    always_comb begin
        hp_we = 1'b0;
        hp_wa = r_pos;
        hp_wd = r_x;
        hp_re = 1'b0;
        hp_ra = '0;
        nd_we = 1'b0;
        nd_wa = r_nodes[NAW-1:0];
        nd_wd = '{sym: r_sym, leaf: 1'b1, left: '0, right: '0};
        nd_re = 1'b0;
        nd_ra = r_cursor;
        case (i_ctl.op)
            OP_INS_START: begin
                nd_we = 1'b1;
            end
            OP_MERGE: begin
                nd_we = 1'b1;
                nd_wd = '{sym: 8'd0, leaf: 1'b0, left: r_a.idx, right: r_b.idx};
            end
            OP_UP_READ: begin
                hp_re = 1'b1;
                hp_ra = up_ix;
            end
            OP_UP_STEP: begin
                hp_we = 1'b1;
                hp_wd = r_heap_rd;
            end
            OP_PLACE: begin
                hp_we = 1'b1;
            end
            OP_POP_READ, OP_ROOT_READ: begin
                hp_re = 1'b1;
            end
            OP_POP_TAKE: begin
                hp_re = 1'b1;
                hp_ra = cnt_m1[HAW-1:0];
            end
            OP_DN_READL: begin
                hp_re = 1'b1;
                hp_ra = l_ix[HAW-1:0];
            end
            OP_DN_READR: begin
                hp_re = 1'b1;
                hp_ra = r_ix[HAW-1:0];
            end
            OP_DN_MOVE: begin
                hp_we = 1'b1;
                hp_wd = dn_best;
            end
            OP_DEC_READ: begin
                nd_re = 1'b1;
            end
            OP_DEC_CHILD: begin
                nd_re = 1'b1;
                nd_ra = child_c;
            end
            default: begin
                hp_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (hp_we) begin
            r_heap_mem[hp_wa] <= hp_wd;
        end
        if (hp_re) begin
            r_heap_rd <= r_heap_mem[hp_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (nd_we) begin
            r_node_mem[nd_wa] <= nd_wd;
        end
        if (nd_re) begin
            r_node_rd <= r_node_mem[nd_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_nodes     <= '0;
            r_root      <= '0;
            r_cursor    <= '0;
            r_tree      <= 1'b0;
            r_root_leaf <= 1'b0;
        end else begin
            case (i_ctl.op)
                OP_INS_START, OP_MERGE: begin
                    r_count <= r_count + CW'(1);
                    r_nodes <= r_nodes + NUW'(1);
                end
                OP_POP_TAKE: begin
                    r_count <= cnt_m1;
                end
                OP_ROOT_SET: begin
                    r_root      <= r_heap_rd.idx;
                    r_cursor    <= r_heap_rd.idx;
                    r_tree      <= 1'b1;
                    r_root_leaf <= (r_nodes == NUW'(1));
                end
                OP_DEC_FIN: begin
                    r_cursor <= c_fin;
                end
                default: begin
                    r_tree <= r_tree;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_CAPTURE: begin
                r_cmd  <= i_cmd;
                r_sym  <= i_symbol;
                r_wt   <= i_weight;
                r_bit  <= i_code_bit;
                r_last <= i_last_bit;
            end
            OP_RESULT: begin
                r_osym  <= 8'd0;
                r_oemit <= 1'b0;
                r_ostat <= i_ctl.stat;
            end
            OP_INS_START: begin
                r_x   <= '{w: w_sat, idx: r_nodes[NAW-1:0]};
                r_pos <= r_count[HAW-1:0];
            end
            OP_MERGE: begin
                r_x   <= '{w: sum_sat, idx: r_nodes[NAW-1:0]};
                r_pos <= r_count[HAW-1:0];
            end
            OP_UP_STEP: begin
                r_pos <= up_ix;
            end
            OP_PLACE, OP_ROOT_SET: begin
                r_osym  <= 8'd0;
                r_oemit <= 1'b0;
                r_ostat <= ST_OK;
            end
            OP_POP_TAKE: begin
                if (i_ctl.phase_b) begin
                    r_b <= r_heap_rd;
                end else begin
                    r_a <= r_heap_rd;
                end
            end
            OP_POP_LAST: begin
                r_x   <= r_heap_rd;
                r_pos <= '0;
            end
            OP_DN_READR: begin
                r_lent <= r_heap_rd;
                r_rin  <= (r_ix < count_ext);
            end
            OP_DN_MOVE: begin
                r_pos <= dn_bi;
            end
            OP_DEC_CHILD: begin
                r_child <= child_c;
            end
            OP_DEC_FIN: begin
                r_osym  <= r_node_rd.leaf ? r_node_rd.sym : 8'd0;
                r_oemit <= r_node_rd.leaf;
                r_ostat <= ST_OK;
            end
            default: begin
                r_pos <= r_pos;
            end
        endcase
    end

    assign o_sts.cmd        = r_cmd;
    assign o_sts.tree_ready = r_tree;
    assign o_sts.root_leaf  = r_root_leaf;
    assign o_sts.heap_full  = (r_count >= CW'(MAX_SYMBOLS));
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.count_gt1  = (r_count > CW'(1));
    assign o_sts.pos_zero   = (r_pos == '0);
    assign o_sts.up_less    = (r_x.w < r_heap_rd.w);
    assign o_sts.l_in       = (l_ix < count_ext);
    assign o_sts.dn_stay    = !dn_moved;

    assign o_decoded_symbol = r_osym;
    assign o_emitted        = r_oemit;
    assign o_status         = r_ostat;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SYMBOLS))
        else $error("heap count beyond capacity");

    a_nodes_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nodes <= NUW'(NDEPTH))
        else $error("node store overrun");

    a_cursor_in_tree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tree |-> (NUW'(r_cursor) < r_nodes))
        else $error("decode cursor outside written nodes");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.op == OP_POP_TAKE) |-> (r_count != '0))
        else $error("pop from empty heap");

    a_leaf_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tree && r_root_leaf) |-> (r_nodes == NUW'(1)))
        else $error("leaf root with more than one node");

endmodule
`default_nettype wire

>>> hw/rtl/huffman_tree_build_and_decode.sv
// Huffman tree builder and bit-serial decoder, top level.
// One command per transaction, one result per command; the block works on one item at a time.
// The heap lives in a memory with one read and one write port, holding {weight, node index}.
// An insert climbs L levels of the heap, a parent read and a step per level, and stops at the top
// or below a parent no heavier (L is at most log2 of MAX_SYMBOLS). A build of N leaves does N-1
// merges, each two pops and one push, then fixes the root. A decode bit takes two node memory
// reads. Each result, also an error, is held until the receiver takes it.
// No clearing pass is needed after reset.
`default_nettype none
module huffman_tree_build_and_decode
    import htbd_pkg::*;
#(
    parameter int MAX_SYMBOLS = 256,
    parameter int WEIGHT_BITS = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    htbd_in_if.sink      i_in,
    htbd_out_if.source   o_out
);

    t_ctl ctl;
    t_sts sts;

    htbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    htbd_dpath #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .o_sts            (sts),
        .i_cmd            (i_in.cmd),
        .i_symbol         (i_in.symbol),
        .i_weight         (i_in.weight),
        .i_code_bit       (i_in.code_bit),
        .i_last_bit       (i_in.last_bit),
        .o_decoded_symbol (o_out.decoded_symbol),
        .o_emitted        (o_out.emitted),
        .o_status         (o_out.status)
    );

endmodule
`default_nettype wire
